>>> rtl/gscu_pkg.sv
// Shared constants, command type and case decode for the Gauss-Seidel cell engine.
package gscu_pkg;

	localparam int GRID_COLS_DEF = 128;
	localparam int GRID_ROWS_DEF = 128;
	localparam int ADDR_MAX_W    = 20;
	localparam int QUEUE_DEPTH   = 2;
	localparam int DATA_W        = 32;
	localparam int DIST_W        = 31;
	localparam int NUM_W         = 51;
	localparam int DEN_W         = 35;
	localparam int SDATA_W       = 280;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] SIDE_CELL = 2'd0;
	localparam logic [1:0] SIDE_DIRI = 2'd1;
	localparam logic [1:0] SIDE_NEUM = 2'd2;

	localparam logic [1:0] SIDE_N = 2'd0;
	localparam logic [1:0] SIDE_S = 2'd1;
	localparam logic [1:0] SIDE_E = 2'd2;
	localparam logic [1:0] SIDE_W = 2'd3;

	localparam logic [7:0] KEEP_CELL = 8'hFF;

	typedef struct packed {
		logic [1:0]                  op;
		logic                        in_grid;
		logic                        keep;
		logic [3:0][1:0]             kind;
		logic [ADDR_MAX_W-1:0]       addr;
		logic [3:0][ADDR_MAX_W-1:0]  nb_addr;
		logic [3:0]                  nb_ok;
		logic [3:0][DATA_W-1:0]      coef;
		logic [DATA_W-1:0]           coef_center;
		logic [DIST_W-1:0]           dist_h;
		logic [DIST_W-1:0]           dist_v;
		logic [DATA_W-1:0]           load_value;
	} cmd_t;

	// Two bits per side: N 1:0, S 3:2, E 5:4, W 7:6.
	function automatic logic [7:0] case_kinds(input logic [5:0] code);
		logic [7:0] k;
		case (code)
			6'd0:  k = 8'h00;
			6'd1:  k = 8'h01;
			6'd2:  k = 8'h04;
			6'd3:  k = 8'h10;
			6'd4:  k = 8'h40;
			6'd5:  k = 8'h11;
			6'd6:  k = 8'h41;
			6'd7:  k = 8'h44;
			6'd8:  k = 8'h14;
			6'd9:  k = 8'h02;
			6'd10: k = 8'h08;
			6'd11: k = 8'h20;
			6'd12: k = 8'h80;
			6'd13: k = 8'h22;
			6'd14: k = 8'h82;
			6'd15: k = 8'h28;
			6'd16: k = 8'h88;
			6'd25: k = 8'h21;
			6'd27: k = 8'h12;
			6'd31: k = 8'h81;
			6'd33: k = 8'h42;
			6'd37: k = 8'h24;
			6'd39: k = 8'h18;
			6'd43: k = 8'h84;
			6'd45: k = 8'h48;
			default: k = KEEP_CELL;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/gscu_ram.sv
// Generic single-port RAM with registered read.
module gscu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/gscu_queue.sv
// Short command queue between the front and the back.
module gscu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/gscu_front.sv
// Front end: accepts input beats, decodes the case and computes cell addresses.
module gscu_front #(
	parameter int GRID_COLS = gscu_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gscu_pkg::GRID_ROWS_DEF
) (
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [gscu_pkg::SDATA_W-1:0] s_tdata,
	input  logic [1:0]                  s_tuser,
	input  logic                        q_full,
	output logic                        q_push,
	output gscu_pkg::cmd_t              cmd
);

	localparam int AW = gscu_pkg::ADDR_MAX_W;

	logic [6:0] col, row;
	logic [5:0] code;
	logic [7:0] kinds;
	logic [AW-1:0] base;

	assign col  = s_tdata[6:0];
	assign row  = s_tdata[13:7];
	assign code = s_tdata[19:14];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		kinds = gscu_pkg::case_kinds(code);
		base  = AW'(int'(row) * GRID_COLS + int'(col));

		cmd.op      = s_tuser;
		cmd.in_grid = (int'(col) < GRID_COLS) && (int'(row) < GRID_ROWS)
			&& (s_tuser != gscu_pkg::OP_NONE);
		cmd.keep    = (kinds == gscu_pkg::KEEP_CELL);
		cmd.kind[gscu_pkg::SIDE_N] = kinds[1:0];
		cmd.kind[gscu_pkg::SIDE_S] = kinds[3:2];
		cmd.kind[gscu_pkg::SIDE_E] = kinds[5:4];
		cmd.kind[gscu_pkg::SIDE_W] = kinds[7:6];
		cmd.addr    = base;

		cmd.nb_addr[gscu_pkg::SIDE_N] = base + AW'(GRID_COLS);
		cmd.nb_addr[gscu_pkg::SIDE_S] = base - AW'(GRID_COLS);
		cmd.nb_addr[gscu_pkg::SIDE_E] = base + 1'b1;
		cmd.nb_addr[gscu_pkg::SIDE_W] = base - 1'b1;
		cmd.nb_ok[gscu_pkg::SIDE_N] = (int'(row) + 1 < GRID_ROWS);
		cmd.nb_ok[gscu_pkg::SIDE_S] = (row != '0);
		cmd.nb_ok[gscu_pkg::SIDE_E] = (int'(col) + 1 < GRID_COLS);
		cmd.nb_ok[gscu_pkg::SIDE_W] = (col != '0);

		cmd.coef[gscu_pkg::SIDE_N] = s_tdata[51:20];
		cmd.coef[gscu_pkg::SIDE_S] = s_tdata[83:52];
		cmd.coef[gscu_pkg::SIDE_E] = s_tdata[115:84];
		cmd.coef[gscu_pkg::SIDE_W] = s_tdata[147:116];
		cmd.coef_center = s_tdata[179:148];
		cmd.dist_h      = s_tdata[210:180];
		cmd.dist_v      = s_tdata[241:211];
		cmd.load_value  = s_tdata[273:242];
	end

endmodule

>>> rtl/gscu_back.sv
// Back end: gathers cells, sums the stencil terms, divides and writes back.
module gscu_back #(
	parameter int GRID_COLS = gscu_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gscu_pkg::GRID_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	output logic                      q_pop,
	input  gscu_pkg::cmd_t            q_cmd,
	input  logic [3:0][31:0]          wall,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,
	output logic                      m_tuser
);

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = gscu_pkg::NUM_W;
	localparam int DW    = gscu_pkg::DEN_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_GHOST = 4'd2;
	localparam logic [3:0] ST_TERM  = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_DIVI  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] cnt_q;
	logic [1:0] side_q;
	gscu_pkg::cmd_t cmd_q;
	logic [31:0] ctr_q;
	logic [3:0][31:0] nb_q;
	logic signed [63:0] p_q;
	logic signed [NW-1:0] num_q;
	logic signed [DW-1:0] den_q;
	logic [DW-1:0] dabs_q, rem_q;
	logic [31:0] nlo_q, quo_q;
	logic ovf_q, neg_q;
	logic [31:0] res_q;
	logic fault_q;
	logic out_valid_q, out_fault_q;
	logic [31:0] out_value_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_rdata;
	logic done_go, wr_need;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] gsh;
	logic [31:0] ghost, term_v;
	logic [1:0] kind;
	logic [DW:0] t1, t2;
	logic [DW-1:0] r1, r2;
	logic b1, b2;
	logic [NW-1:0] nabs;
	logic [NW+15:0] nfull;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign done_go  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign wr_need  = cmd_q.in_grid && ((cmd_q.op == gscu_pkg::OP_LOAD)
		|| ((cmd_q.op == gscu_pkg::OP_UPDATE) && !cmd_q.keep));
	assign ram_we   = done_go && wr_need;
	assign kind     = cmd_q.kind[side_q];

	always_comb begin
		if ((state_q == ST_READ) && (cnt_q != 4'd0)) begin
			ram_addr = cmd_q.nb_addr[cnt_q[1:0] - 2'd1][AW-1:0];
		end else begin
			ram_addr = cmd_q.addr[AW-1:0];
		end
	end

	gscu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (res_q),
		.rdata (ram_rdata)
	);

	// Ghost value for a Neumann side, saturated to 32 bits, and the term chosen by side kind.
	always_comb begin
		gsh = p_q >>> 15;
		if (gsh > 64'sd2147483647) begin
			ghost = 32'h7FFF_FFFF;
		end else if (gsh < -64'sd2147483648) begin
			ghost = 32'h8000_0000;
		end else begin
			ghost = gsh[31:0];
		end
		case (kind)
			gscu_pkg::SIDE_DIRI: term_v = wall[side_q];
			gscu_pkg::SIDE_NEUM: term_v = ghost;
			default:             term_v = nb_q[side_q];
		endcase
	end

	always_comb begin
		if (state_q == ST_GHOST) begin
			mul_a = $signed(wall[side_q]);
			mul_b = $signed({1'b0, (side_q[1] ? cmd_q.dist_h : cmd_q.dist_v)});
		end else begin
			mul_a = $signed(cmd_q.coef[side_q]);
			mul_b = $signed(term_v);
		end
		mul_p = mul_a * mul_b;
	end

	// Two restoring division steps per cycle.
	always_comb begin
		t1 = {rem_q, nlo_q[31]};
		b1 = (t1 >= {1'b0, dabs_q});
		r1 = b1 ? DW'(t1 - {1'b0, dabs_q}) : t1[DW-1:0];
		t2 = {r1, nlo_q[30]};
		b2 = (t2 >= {1'b0, dabs_q});
		r2 = b2 ? DW'(t2 - {1'b0, dabs_q}) : t2[DW-1:0];
		nabs  = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
		nfull = {nabs, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_READ) begin
			if (cnt_q == 4'd1) begin
				ctr_q <= ram_rdata;
			end else if (cnt_q != 4'd0) begin
				nb_q[cnt_q[1:0] - 2'd2] <=
					cmd_q.nb_ok[cnt_q[1:0] - 2'd2] ? ram_rdata : 32'd0;
			end
		end
		if ((state_q == ST_GHOST) || (state_q == ST_TERM)) begin
			p_q <= mul_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			side_q      <= '0;
			num_q       <= '0;
			den_q       <= '0;
			dabs_q      <= '0;
			rem_q       <= '0;
			nlo_q       <= '0;
			quo_q       <= '0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
			res_q       <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_fault_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cnt_q   <= '0;
						fault_q <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd5) begin
						side_q <= '0;
						num_q  <= '0;
						den_q  <= DW'($signed(cmd_q.coef_center));
						if (!cmd_q.in_grid) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else if (cmd_q.op == gscu_pkg::OP_LOAD) begin
							res_q   <= cmd_q.load_value;
							state_q <= ST_DONE;
						end else if ((cmd_q.op == gscu_pkg::OP_READ) || cmd_q.keep) begin
							res_q   <= ctr_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_GHOST;
						end
					end
				end
				ST_GHOST: state_q <= ST_TERM;
				ST_TERM:  state_q <= ST_ACC;
				ST_ACC: begin
					num_q <= num_q + NW'(p_q >>> 16);
					if (kind == gscu_pkg::SIDE_NEUM) begin
						den_q <= den_q + DW'($signed(cmd_q.coef[side_q]));
					end
					side_q  <= side_q + 1'b1;
					state_q <= (side_q == gscu_pkg::SIDE_W) ? ST_DIVI : ST_GHOST;
				end
				ST_DIVI: begin
					if (den_q == '0) begin
						fault_q <= 1'b1;
						if (num_q > 0) begin
							res_q <= 32'h7FFF_FFFF;
						end else if (num_q < 0) begin
							res_q <= 32'h8000_0000;
						end else begin
							res_q <= '0;
						end
						state_q <= ST_DONE;
					end else begin
						dabs_q  <= den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
						ovf_q   <= (nfull[NW+15:32] >= (den_q[DW-1] ? DW'(-den_q) : DW'(den_q)));
						rem_q   <= nfull[NW+15:32];
						nlo_q   <= nfull[31:0];
						neg_q   <= num_q[NW-1] ^ den_q[DW-1];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= r2;
					nlo_q <= {nlo_q[29:0], 2'b00};
					quo_q <= {quo_q[29:0], b1, b2};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!neg_q) begin
						res_q <= (ovf_q || quo_q[31]) ? 32'h7FFF_FFFF : quo_q;
					end else begin
						res_q <= (ovf_q || (quo_q > 32'h8000_0000)) ? 32'h8000_0000 : -quo_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_go) begin
						out_value_q <= res_q;
						out_fault_q <= fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_fault_q;

endmodule

>>> rtl/gauss_seidel_cell_update.sv
// Top level of the Gauss-Seidel five-point cell engine.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata cell fields, tuser operation
//  m_*       out  tvalid/tready      tdata cell_value, tuser divide_fault
//  APB       in   psel/penable       four boundary registers at 0x0..0xC
//
// An update pops the queue, reads the cell and its neighbours on the single RAM
// port, runs the ghost, term and accumulate states for each side on the shared
// 32x32 multiplier, sets up and runs the two-bit-per-cycle divider, then applies
// sign and saturation and issues the result. A zero denominator skips the
// divider. Load, read and keep items go from the reads straight to issue.
// Reset leaves the RAM untouched; cell contents are undefined until loaded.
// A two-entry queue lets input beats land while the back end works or the
// output register waits for m_tready.
module gauss_seidel_cell_update #(
	parameter int GRID_COLS = gscu_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gscu_pkg::GRID_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// col, row, case_code, coef_north, coef_south, coef_east, coef_west,
	// coef_center, dist_horiz, dist_vert, load_value, zero pad
	input  logic [gscu_pkg::SDATA_W-1:0] s_tdata,
	input  logic [1:0]   s_tuser,    // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,    // cell_value
	output logic         m_tuser     // divide_fault
);

	localparam int CMD_W = $bits(gscu_pkg::cmd_t);

	logic [3:0][31:0] bnd_q;
	logic q_full, q_push, q_empty, q_pop;
	gscu_pkg::cmd_t f_cmd, b_cmd;
	logic [CMD_W-1:0] q_dout;

	assign pready = 1'b1;
	assign prdata = bnd_q[paddr[3:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_q <= '0;
		end else if (psel && penable && pwrite) begin
			bnd_q[paddr[3:2]] <= pwdata;
		end
	end

	gscu_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.cmd      (f_cmd)
	);

	gscu_queue #(.WIDTH(CMD_W), .DEPTH(gscu_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (f_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign b_cmd = gscu_pkg::cmd_t'(q_dout);

	gscu_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_cmd    (b_cmd),
		.wall     (bnd_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> tb/gauss_seidel_cell_update_tb.sv
// Self-checking testbench for the Gauss-Seidel five-point cell engine.
`timescale 1ns / 100ps

module gauss_seidel_cell_update_tb;

	localparam int COLS = 128;
	localparam int ROWS = 128;

	localparam logic [3:0] REG_NORTH = 4'h0;
	localparam logic [3:0] REG_SOUTH = 4'h4;
	localparam logic [3:0] REG_EAST  = 4'h8;
	localparam logic [3:0] REG_WEST  = 4'hC;

	localparam logic [1:0] KIND_CELL = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_FLUX = 2'd2;
	localparam logic [7:0] NO_UPDATE = 8'hFF;

	// Side kinds per case code: N 1:0, S 3:2, E 5:4, W 7:6.
	localparam logic [7:0] SIDE_MAP [64] = '{
		8'h00, 8'h01, 8'h04, 8'h10, 8'h40, 8'h11, 8'h41, 8'h44,
		8'h14, 8'h02, 8'h08, 8'h20, 8'h80, 8'h22, 8'h82, 8'h28,
		8'h88, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'h21, 8'hFF, 8'h12, 8'hFF, 8'hFF, 8'hFF, 8'h81,
		8'hFF, 8'h42, 8'hFF, 8'hFF, 8'hFF, 8'h24, 8'hFF, 8'h18,
		8'hFF, 8'hFF, 8'hFF, 8'h84, 8'hFF, 8'h48, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	typedef struct {
		logic [1:0]  op;
		logic [6:0]  col;
		logic [6:0]  row;
		logic [5:0]  code;
		logic [31:0] coef [5];   // N, S, E, W, center
		logic [30:0] dist_h;
		logic [30:0] dist_v;
		logic [31:0] load_value;
	} cell_cmd_t;

	typedef struct {
		logic [31:0] value;
		logic        fault;
	} cell_result_t;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [gscu_pkg::SDATA_W-1:0] s_tdata;  // col, row, case_code, coef N/S/E/W/center, dist_h, dist_v, load_value
	logic [1:0]   s_tuser;        // operation
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;        // cell_value
	logic         m_tuser;        // divide_fault

	gauss_seidel_cell_update dut (.*);

	cell_cmd_t    cmd_queue [$];
	cell_result_t result_queue [$];
	logic [31:0]  grid [COLS*ROWS];
	logic signed [31:0] wall [4];
	cell_cmd_t    cur_cmd;
	int           gap_left;
	bit           calm;
	int           errors;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic longint neighbour(int c, int r);
		if (c < 0 || r < 0 || c >= COLS || r >= ROWS) return 0;
		return longint'(signed'(grid[r*COLS + c]));
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Apply one command to the shadow grid and return the beat it should produce.
	function automatic cell_result_t apply_cell_cmd(cell_cmd_t c);
		cell_result_t res;
		logic [7:0] kinds;
		logic [1:0] k;
		longint num, den, v, q0, rem, coef, face_dist, q;
		int addr, nc, nr;
		res.value = '0;
		res.fault = 1'b0;
		addr = int'(c.row)*COLS + int'(c.col);
		if (c.op == gscu_pkg::OP_LOAD) begin
			grid[addr] = c.load_value;
			res.value = c.load_value;
		end else if (c.op == gscu_pkg::OP_READ) begin
			res.value = grid[addr];
		end else if (c.op == gscu_pkg::OP_UPDATE) begin
			kinds = SIDE_MAP[c.code];
			res.value = grid[addr];
			if (kinds != NO_UPDATE) begin
				num = 0;
				den = longint'(signed'(c.coef[4]));
				for (int s = 0; s < 4; s++) begin
					k = kinds[2*s +: 2];
					coef = longint'(signed'(c.coef[s]));
					nc = int'(c.col) + (s == 2 ? 1 : (s == 3 ? -1 : 0));
					nr = int'(c.row) + (s == 0 ? 1 : (s == 1 ? -1 : 0));
					face_dist = (s < 2) ? longint'(c.dist_v) : longint'(c.dist_h);
					v = neighbour(nc, nr);
					if (k == KIND_WALL) begin
						v = wall[s];
					end else if (k == KIND_FLUX) begin
						v = clamp32((longint'(wall[s]) * face_dist) >>> 15);
						den += coef;
					end
					num += (coef * v) >>> 16;
				end
				if (den == 0) begin
					res.fault = 1'b1;
					q = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
				end else begin
					q0 = num / den;
					rem = num % den;
					if (q0 >= 32768) q = 64'sd2147483647;
					else if (q0 <= -32769) q = -64'sd2147483648;
					else q = clamp32(q0 * 65536 + (rem * 65536) / den);
				end
				res.value = q[31:0];
				grid[addr] = q[31:0];
			end
		end
		return res;
	endfunction

	// Input driver: predict on each accepted beat, then present the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				result_queue.push_back(apply_cell_cmd(cur_cmd));
			if (s_tvalid && !s_tready) begin
				// hold the beat
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				cur_cmd = cmd_queue.pop_front();
				s_tuser <= cur_cmd.op;
				s_tdata <= {6'd0, cur_cmd.load_value, cur_cmd.dist_v, cur_cmd.dist_h,
					cur_cmd.coef[4], cur_cmd.coef[3], cur_cmd.coef[2], cur_cmd.coef[1],
					cur_cmd.coef[0], cur_cmd.code, cur_cmd.row, cur_cmd.col};
				s_tvalid <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output monitor with random backpressure.
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (result_queue.size() == 0) begin
					if (errors < 10)
						$display("unexpected beat: value %h fault %b", m_tdata, m_tuser);
					errors++;
				end else begin
					want = result_queue.pop_front();
					if (m_tdata !== want.value || m_tuser !== want.fault) begin
						if (errors < 10)
							$display("mismatch: value exp %h got %h, fault exp %b got %b",
								want.value, m_tdata, want.fault, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= calm ? 1'b1 : (pick_gap() == 0);
		end
	end

	task automatic write_wall(logic [3:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		wall[addr[3:2]] = data;
	endtask

	task automatic drain();
		wait (cmd_queue.size() == 0 && !s_tvalid && result_queue.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [6:0] ready_coord();
		int i;
		i = $urandom_range(0, 5);
		return (i < 3) ? 7'(i) : 7'(122 + i);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			default: return $urandom;
		endcase
	endfunction

	function automatic cell_cmd_t blank_cmd(logic [1:0] op, logic [6:0] c, logic [6:0] r);
		cell_cmd_t x;
		x.op = op; x.col = c; x.row = r; x.code = '0;
		for (int i = 0; i < 5; i++) x.coef[i] = '0;
		x.dist_h = '0; x.dist_v = '0; x.load_value = '0;
		return x;
	endfunction

	function automatic cell_cmd_t random_update(logic [5:0] code);
		cell_cmd_t x;
		logic [7:0] kinds;
		logic [31:0] sum;
		x = blank_cmd(gscu_pkg::OP_UPDATE, ready_coord(), ready_coord());
		x.code = code;
		for (int i = 0; i < 5; i++) x.coef[i] = rand_word();
		x.dist_h = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
		x.dist_v = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
		x.load_value = $urandom;
		// force a zero denominator now and then
		if ($urandom_range(0, 9) == 0) begin
			kinds = SIDE_MAP[code];
			sum = '0;
			for (int s = 0; s < 4; s++)
				if (kinds[2*s +: 2] == KIND_FLUX) sum += x.coef[s];
			x.coef[4] = -sum;
		end
		return x;
	endfunction

	function automatic logic [5:0] random_code();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 6'($urandom_range(0, 16));
		if (r < 8) begin
			case ($urandom_range(0, 7))
				0: return 6'd25; 1: return 6'd27; 2: return 6'd31; 3: return 6'd33;
				4: return 6'd37; 5: return 6'd39; 6: return 6'd43; default: return 6'd45;
			endcase
		end
		return 6'($urandom_range(0, 63));
	endfunction

	task automatic random_phase(int count);
		cell_cmd_t x;
		int r;
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 19);
			if (r < 13) begin
				x = random_update(random_code());
			end else if (r < 16) begin
				if (r == 13)
					x = blank_cmd(gscu_pkg::OP_LOAD, 7'($urandom), 7'($urandom));
				else
					x = blank_cmd(gscu_pkg::OP_LOAD, ready_coord(), ready_coord());
				x.load_value = rand_word();
				x.code = 6'($urandom);
				x.dist_h = 31'($urandom); x.dist_v = 31'($urandom);
			end else if (r < 19) begin
				x = blank_cmd(gscu_pkg::OP_READ, ready_coord(), ready_coord());
			end else begin
				x = blank_cmd(gscu_pkg::OP_NONE, 7'($urandom), 7'($urandom));
				x.load_value = $urandom;
			end
			cmd_queue.push_back(x);
		end
		drain();
	endtask

	initial begin
		cell_cmd_t x;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = gscu_pkg::OP_NONE; m_tready = 1'b0;
		gap_left = 0; calm = 1'b0; errors = 0;
		for (int i = 0; i < 4; i++) wall[i] = '0;
		foreach (grid[i]) grid[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_wall(REG_NORTH, 32'h0001_0000);
		write_wall(REG_SOUTH, 32'hFFFF_0000);
		write_wall(REG_EAST,  32'h0002_8000);
		write_wall(REG_WEST,  32'h0000_4000);

		// Fill the four corner blocks that updates and reads draw on.
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++) begin
				x = blank_cmd(gscu_pkg::OP_LOAD, (c < 4) ? 7'(c) : 7'(120 + c),
					(r < 4) ? 7'(r) : 7'(120 + r));
				x.load_value = (r == 0 && c == 1) ? 32'h7FFF_FFFF :
					(r == 1 && c == 0) ? 32'h8000_0000 :
					32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
				cmd_queue.push_back(x);
			end

		// Directed: update codes 0 to 16, a zero denominator, keep codes, no-op and reads.
		for (int k = 0; k < 17; k++) cmd_queue.push_back(random_update(6'(k)));
		x = random_update(6'd1);
		x.coef[4] = '0;
		cmd_queue.push_back(x);
		x = random_update(6'd0);
		for (int i = 0; i < 5; i++) x.coef[i] = '0;
		cmd_queue.push_back(x);
		x = random_update(6'd9);
		x.coef[0] = 32'h7FFF_FFFF; x.coef[4] = 32'h8000_0001;
		x.dist_v = 31'h7FFF_FFFF;
		cmd_queue.push_back(x);
		cmd_queue.push_back(random_update(6'd17));
		cmd_queue.push_back(random_update(6'd63));
		cmd_queue.push_back(blank_cmd(gscu_pkg::OP_NONE, 7'h7F, 7'h7F));
		cmd_queue.push_back(blank_cmd(gscu_pkg::OP_READ, 7'd0, 7'd1));
		cmd_queue.push_back(blank_cmd(gscu_pkg::OP_READ, 7'd127, 7'd127));
		drain();

		random_phase(350);

		write_wall(REG_NORTH, 32'h7FFF_FFFF);
		write_wall(REG_SOUTH, 32'h8000_0000);
		write_wall(REG_EAST,  32'h8000_0000);
		write_wall(REG_WEST,  32'h7FFF_FFFF);
		random_phase(300);

		write_wall(REG_NORTH, 32'h0000_0000);
		write_wall(REG_SOUTH, 32'h0000_0000);
		write_wall(REG_EAST,  32'h0000_0000);
		write_wall(REG_WEST,  32'h0000_0000);
		random_phase(300);

		write_wall(REG_NORTH, $urandom);
		write_wall(REG_SOUTH, $urandom);
		write_wall(REG_EAST,  32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
		write_wall(REG_WEST,  32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
		random_phase(300);

		repeat (100) @(posedge clk);
		if (errors == 0 && result_queue.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
